FILE: hdl/sfsan_pkg.sv
// ----------------------------------------------------------------------------
// sfsan_pkg
// Shared constants, register indexes and controller/datapath bundles for the
// stick frame sync and axis normalizer.
// ----------------------------------------------------------------------------
package sfsan_pkg;

  localparam int FRAME_LEN = 6;
  localparam int FILL_W    = 3;
  localparam int BYTE_W    = 8;
  localparam int POS_W     = 17;
  localparam int NUM_W     = 23;
  localparam int CNT_W     = 5;
  localparam int IDX_W     = 3;

  localparam logic [BYTE_W-1:0] HEAD_MARK = 8'hFF;
  localparam logic [BYTE_W-1:0] TAIL_MARK = 8'hFE;

  localparam logic [NUM_W-1:0] NEG_MAG = 23'd32768;
  localparam logic [NUM_W-1:0] POS_MAX = 23'd32767;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_X_MIN     = 3'd0;
  localparam logic [IDX_W-1:0] REG_X_MAX     = 3'd1;
  localparam logic [IDX_W-1:0] REG_X_CENTER  = 3'd2;
  localparam logic [IDX_W-1:0] REG_Y_MIN     = 3'd3;
  localparam logic [IDX_W-1:0] REG_Y_MAX     = 3'd4;
  localparam logic [IDX_W-1:0] REG_Y_CENTER  = 3'd5;
  localparam logic [IDX_W-1:0] REG_DEAD_BAND = 3'd6;
  localparam logic [IDX_W-1:0] REG_AXIS_MODE = 3'd7;

  // Controller to datapath
  typedef struct packed {
    logic shift;   // take the accepted byte into the window
    logic start;   // load the divider for the selected axis
    logic store;   // store the finished axis value
    logic emit;    // load the output register and the previous values
    logic sel_y;   // axis being worked on: 0 X, 1 Y
  } sfsan_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic framed;    // window full and framed by head and tail marks
    logic div_busy;  // divider still iterating
    logic changed;   // new X/Y differ from the previous frame, or first frame
    logic out_busy;  // output register holds a request that is not taken
  } sfsan_stat_t;

endpackage

FILE: hdl/sfsan_if.sv
// ----------------------------------------------------------------------------
// sfsan interfaces
// Valid/ready channels for the received bytes, the normalized positions and
// the configuration writes.
// ----------------------------------------------------------------------------
interface sfsan_in_if;
  logic                          valid;
  logic                          ready;
  logic [sfsan_pkg::BYTE_W-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfsan_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sfsan_pkg::POS_W-1:0]  x_pos;
  logic signed [sfsan_pkg::POS_W-1:0]  y_pos;

  modport source (output valid, output x_pos, output y_pos, input ready);
  modport sink   (input valid, input x_pos, input y_pos, output ready);
endinterface

interface sfsan_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sfsan_pkg::IDX_W-1:0]   index;
  logic [sfsan_pkg::BYTE_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/sfsan_div.sv
// ----------------------------------------------------------------------------
// sfsan_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfsan_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sfsan_pkg::NUM_W-1:0]   num,
  input  logic [sfsan_pkg::BYTE_W-1:0]  den,
  output logic                          busy,
  output logic [sfsan_pkg::NUM_W-1:0]   quo
);

  logic                          busy_r;
  logic [sfsan_pkg::CNT_W-1:0]   cnt_r;
  logic [sfsan_pkg::BYTE_W-1:0]  rem_r, rem_nxt;
  logic [sfsan_pkg::BYTE_W-1:0]  den_r;
  logic [sfsan_pkg::NUM_W-1:0]   quo_r, quo_nxt;
  logic [sfsan_pkg::BYTE_W:0]    trial;
  logic [sfsan_pkg::BYTE_W:0]    diff;
  logic                          qbit;

  always_comb begin
    trial = {rem_r, quo_r[sfsan_pkg::NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    qbit  = (trial >= {1'b0, den_r});
    rem_nxt = qbit ? diff[sfsan_pkg::BYTE_W-1:0] : trial[sfsan_pkg::BYTE_W-1:0];
    quo_nxt = {quo_r[sfsan_pkg::NUM_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= sfsan_pkg::CNT_W'(sfsan_pkg::NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == sfsan_pkg::CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

FILE: hdl/sfsan_dp.sv
// ----------------------------------------------------------------------------
// sfsan_dp
// Datapath: configuration registers, byte window, axis normalization around
// the shared divider, change detect and the output register.
// ----------------------------------------------------------------------------
module sfsan_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  sfsan_pkg::sfsan_cmd_t               cmd,
  output sfsan_pkg::sfsan_stat_t              stat,
  input  logic [sfsan_pkg::BYTE_W-1:0]        in_byte,
  input  logic                                cfg_we,
  input  logic [sfsan_pkg::IDX_W-1:0]         cfg_index,
  input  logic [sfsan_pkg::BYTE_W-1:0]        cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sfsan_pkg::POS_W-1:0]  out_x,
  output logic signed [sfsan_pkg::POS_W-1:0]  out_y
);

  localparam int BW = sfsan_pkg::BYTE_W;
  localparam int PW = sfsan_pkg::POS_W;
  localparam int NW = sfsan_pkg::NUM_W;

  // Configuration
  logic [BW-1:0] cal_x_min_r, cal_x_max_r, cal_x_center_r;
  logic [BW-1:0] cal_y_min_r, cal_y_max_r, cal_y_center_r;
  logic [6:0]    dead_band_r;
  logic [5:0]    axis_mode_r;

  // Window
  logic [BW-1:0]                 win_r [sfsan_pkg::FRAME_LEN];
  logic [sfsan_pkg::FILL_W-1:0]  fill_r;

  // Axis preparation
  logic [1:0]        src;
  logic [2:0]        raw_idx;
  logic [BW-1:0]     raw, lo, hi, mid;
  logic [BW:0]       delta;
  logic              neg;
  logic [BW-1:0]     mag;
  logic              in_band;
  logic [BW:0]       span;
  logic [BW-1:0]     den;
  logic [NW-1:0]     num;
  logic              neg_r, band_r;
  logic              inv;

  // Divider
  logic              div_busy;
  logic [NW-1:0]     quo;

  // Result
  logic [NW-1:0]         lim, magc;
  logic signed [PW-1:0]  mag17, res;
  logic signed [PW-1:0]  x_r, y_r;
  logic signed [PW-1:0]  prev_x_r, prev_y_r;
  logic                  have_prev_r;
  logic                  out_valid_r;
  logic signed [PW-1:0]  out_x_r, out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_x_min_r    <= 8'd14;
      cal_x_max_r    <= 8'd235;
      cal_x_center_r <= 8'd126;
      cal_y_min_r    <= 8'd18;
      cal_y_max_r    <= 8'd232;
      cal_y_center_r <= 8'd130;
      dead_band_r    <= 7'd8;
      axis_mode_r    <= 6'd11;
    end else if (cfg_we) begin
      case (cfg_index)
        sfsan_pkg::REG_X_MIN:     cal_x_min_r    <= cfg_data;
        sfsan_pkg::REG_X_MAX:     cal_x_max_r    <= cfg_data;
        sfsan_pkg::REG_X_CENTER:  cal_x_center_r <= cfg_data;
        sfsan_pkg::REG_Y_MIN:     cal_y_min_r    <= cfg_data;
        sfsan_pkg::REG_Y_MAX:     cal_y_max_r    <= cfg_data;
        sfsan_pkg::REG_Y_CENTER:  cal_y_center_r <= cfg_data;
        sfsan_pkg::REG_DEAD_BAND: dead_band_r    <= cfg_data[6:0];
        sfsan_pkg::REG_AXIS_MODE: axis_mode_r    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Newest byte enters at the top; once full, slot 0 is the oldest.
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int i = 0; i < sfsan_pkg::FRAME_LEN - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[sfsan_pkg::FRAME_LEN-1] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.shift && fill_r != sfsan_pkg::FILL_W'(sfsan_pkg::FRAME_LEN)) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  always_comb begin
    src     = cmd.sel_y ? axis_mode_r[3:2] : axis_mode_r[1:0];
    raw_idx = {1'b0, src} + 3'd1;
    raw     = win_r[raw_idx];
    lo      = cmd.sel_y ? cal_y_min_r    : cal_x_min_r;
    hi      = cmd.sel_y ? cal_y_max_r    : cal_x_max_r;
    mid     = cmd.sel_y ? cal_y_center_r : cal_x_center_r;
    inv     = cmd.sel_y ? axis_mode_r[5] : axis_mode_r[4];
    delta   = {1'b0, raw} - {1'b0, mid};
    neg     = delta[BW];
    mag     = neg ? BW'(-delta) : delta[BW-1:0];
    in_band = ({1'b0, mag} <= {2'b00, dead_band_r});
    span    = neg ? ({1'b0, mid} - {1'b0, lo}) : ({1'b0, hi} - {1'b0, mid});
    den     = (span[BW] || span == '0) ? BW'(1) : span[BW-1:0];
    num     = neg ? {mag, 15'd0} : ({mag, 15'd0} - {15'd0, mag});
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      neg_r  <= neg;
      band_r <= in_band;
    end
  end

  sfsan_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .num   (num),
    .den   (den),
    .busy  (div_busy),
    .quo   (quo)
  );

  // Dead band gives zero; else clamp the magnitude, then apply the sign of the offset and the invert bit.
  always_comb begin
    lim   = neg_r ? sfsan_pkg::NEG_MAG : sfsan_pkg::POS_MAX;
    magc  = (quo > lim) ? lim : quo;
    mag17 = magc[PW-1:0];
    if (band_r) begin
      res = '0;
    end else if (neg_r ^ inv) begin
      res = -mag17;
    end else begin
      res = mag17;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      if (cmd.sel_y) begin
        y_r <= res;
      end else begin
        x_r <= res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        prev_x_r    <= x_r;
        prev_y_r    <= y_r;
        have_prev_r <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x_r <= x_r;
      out_y_r <= y_r;
    end
  end

  always_comb begin
    stat.framed   = (fill_r == sfsan_pkg::FILL_W'(sfsan_pkg::FRAME_LEN)) &&
                    (win_r[0] == sfsan_pkg::HEAD_MARK) &&
                    (win_r[sfsan_pkg::FRAME_LEN-1] == sfsan_pkg::TAIL_MARK);
    stat.div_busy = div_busy;
    stat.changed  = !have_prev_r || (x_r != prev_x_r) || (y_r != prev_y_r);
    stat.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;

endmodule

FILE: hdl/sfsan_ctrl.sv
// ----------------------------------------------------------------------------
// sfsan_ctrl
// Controller: takes a byte, checks framing, runs X then Y through the shared
// divider and hands a changed result to the output register.
// ----------------------------------------------------------------------------
module sfsan_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  sfsan_pkg::sfsan_stat_t  stat,
  output sfsan_pkg::sfsan_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_XSTART = 3'd2;
  localparam logic [2:0] S_XWAIT  = 3'd3;
  localparam logic [2:0] S_YSTART = 3'd4;
  localparam logic [2:0] S_YWAIT  = 3'd5;
  localparam logic [2:0] S_CMP    = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.shift = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = stat.framed ? S_XSTART : S_IDLE;
      end
      S_XSTART: begin
        cmd.start = 1'b1;
        state_nxt = S_XWAIT;
      end
      S_XWAIT: begin
        if (!stat.div_busy) begin
          cmd.store = 1'b1;
          state_nxt = S_YSTART;
        end
      end
      S_YSTART: begin
        cmd.sel_y = 1'b1;
        cmd.start = 1'b1;
        state_nxt = S_YWAIT;
      end
      S_YWAIT: begin
        cmd.sel_y = 1'b1;
        if (!stat.div_busy) begin
          cmd.store = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (!stat.changed) begin
          state_nxt = S_IDLE;
        end else if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/stick_frame_sync_axis_normalizer_core.sv
// ----------------------------------------------------------------------------
// stick_frame_sync_axis_normalizer_core
// Frame sync on a serial stick byte stream and calibrated X/Y normalization.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   carries one received byte per request. Bytes fill a six-byte
//           sliding window; every window that starts with 0xFF and ends with
//           0xFE is a frame of four raw axes.
//   out_ch  carries one request of signed 17-bit x_pos/y_pos per frame whose
//           values differ from the last delivered pair (first frame always).
//   cfg_ch  writes calibration, dead band and axis mode by register index;
//           it is always ready and should be used only while the block idles.
// Sequence:
//   A byte that completes no frame occupies the block only for the framing
//   check. A framed byte then runs 23 divider iterations for each of X and Y,
//   one after the other, on the one shared restoring divider, then compares
//   and loads a changed result into the output register once that is free.
// Stall:
//   A pending result sits in the output register while new bytes are taken;
//   a second changed result waits in the controller until that one is taken.
// Reset:
//   rst_n (synchronous) empties the window, forgets the previous frame,
//   drops any pending request and reloads the default calibration.
// ----------------------------------------------------------------------------
module stick_frame_sync_axis_normalizer_core (
  input  logic        clk,
  input  logic        rst_n,
  sfsan_in_if.sink    in_ch,
  sfsan_out_if.source out_ch,
  sfsan_cfg_if.sink   cfg_ch
);

  sfsan_pkg::sfsan_cmd_t   cmd;
  sfsan_pkg::sfsan_stat_t  stat;
  logic                    in_ready;

  // Configuration registers always take a write.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  sfsan_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfsan_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_byte   (in_ch.rx_byte),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_x     (out_ch.x_pos),
    .out_y     (out_ch.y_pos)
  );

endmodule

FILE: tb/tb_stick_frame_sync_axis_normalizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stick_frame_sync_axis_normalizer_core
// This testbench streams serial bytes into the frame sync and axis normalizer.
// It predicts every framed window on the byte that completes it and checks
// each position request that the block delivers. Predictions come from a
// behavioral copy of the calibration math. The run covers directed frames
// at the reset calibration and at the extreme calibrations, all 64 axis mode
// settings, and random phases of framed, broken, overlapping and noise
// traffic. The sender works in random bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module tb_stick_frame_sync_axis_normalizer_core;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 64;   // > framed byte occupancy
  localparam int MAX_REPORTS   = 40;
  localparam int RANDOM_PHASES = 4;
  localparam int BYTES_TARGET  = 950;

  typedef struct packed {
    logic signed [sfsan_pkg::POS_W-1:0] x;
    logic signed [sfsan_pkg::POS_W-1:0] y;
  } stick_pos_t;

  logic clk;
  logic rst_n;

  sfsan_in_if  in_ch ();
  sfsan_out_if out_ch ();
  sfsan_cfg_if cfg_ch ();

  stick_frame_sync_axis_normalizer_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Shadow copy of the calibration registers
  logic [sfsan_pkg::BYTE_W-1:0] cal_xlo, cal_xhi, cal_xmid;
  logic [sfsan_pkg::BYTE_W-1:0] cal_ylo, cal_yhi, cal_ymid;
  logic [6:0]                   band;
  logic [5:0]                   mode;

  // Shadow copy of the frame tracking state
  logic [sfsan_pkg::BYTE_W-1:0] win [sfsan_pkg::FRAME_LEN];
  int                           fill;
  stick_pos_t                   last_pos;
  bit                           have_last;

  // Positions still owed by the block, oldest first
  stick_pos_t pending_pos [$];

  logic [sfsan_pkg::BYTE_W-1:0] last_raw [4];

  int mismatches        = 0;
  int bytes_sent        = 0;
  int frames_seen       = 0;
  int positions_checked = 0;
  int cfg_writes        = 0;
  int cycles            = 0;
  int burst_left        = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Scale one raw axis against its calibration. Division truncates toward
  // zero, a non-positive half span counts as 1, clamp before inversion so an
  // inverted full negative travel lands on +32768.
  function automatic logic signed [sfsan_pkg::POS_W-1:0] predict_axis(
    input int raw, input int lo, input int hi, input int mid,
    input int dz, input bit flip);
    int delta;
    int span;
    int v;
    delta = raw - mid;
    if (delta >= -dz && delta <= dz)
      return '0;
    if (delta < 0) begin
      span = mid - lo;
      if (span <= 0)
        span = 1;
      v = (delta * int'(sfsan_pkg::NEG_MAG)) / span;
    end else begin
      span = hi - mid;
      if (span <= 0)
        span = 1;
      v = (delta * int'(sfsan_pkg::POS_MAX)) / span;
    end
    if (v < -int'(sfsan_pkg::NEG_MAG))
      v = -int'(sfsan_pkg::NEG_MAG);
    if (v > int'(sfsan_pkg::POS_MAX))
      v = int'(sfsan_pkg::POS_MAX);
    if (flip)
      v = -v;
    return v[sfsan_pkg::POS_W-1:0];
  endfunction

  // Sample every channel at the rising edge: track register writes, predict
  // on each accepted byte, and check each accepted position request.
  always @(posedge clk) begin
    stick_pos_t p;
    stick_pos_t want;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        cfg_writes++;
        case (cfg_ch.index)
          sfsan_pkg::REG_X_MIN:     cal_xlo  = cfg_ch.data;
          sfsan_pkg::REG_X_MAX:     cal_xhi  = cfg_ch.data;
          sfsan_pkg::REG_X_CENTER:  cal_xmid = cfg_ch.data;
          sfsan_pkg::REG_Y_MIN:     cal_ylo  = cfg_ch.data;
          sfsan_pkg::REG_Y_MAX:     cal_yhi  = cfg_ch.data;
          sfsan_pkg::REG_Y_CENTER:  cal_ymid = cfg_ch.data;
          sfsan_pkg::REG_DEAD_BAND: band     = cfg_ch.data[6:0];
          sfsan_pkg::REG_AXIS_MODE: mode     = cfg_ch.data[5:0];
          default: ;
        endcase
      end

      if (in_ch.valid && in_ch.ready) begin
        // Fill the window, then slide it one byte per request
        if (fill < sfsan_pkg::FRAME_LEN) begin
          win[fill] = in_ch.rx_byte;
          fill++;
        end else begin
          for (int i = 0; i < sfsan_pkg::FRAME_LEN - 1; i++)
            win[i] = win[i + 1];
          win[sfsan_pkg::FRAME_LEN - 1] = in_ch.rx_byte;
        end
        if (fill == sfsan_pkg::FRAME_LEN && win[0] == sfsan_pkg::HEAD_MARK &&
            win[sfsan_pkg::FRAME_LEN - 1] == sfsan_pkg::TAIL_MARK) begin
          frames_seen++;
          p.x = predict_axis(win[1 + mode[1:0]], cal_xlo, cal_xhi, cal_xmid,
                             band, mode[4]);
          p.y = predict_axis(win[1 + mode[3:2]], cal_ylo, cal_yhi, cal_ymid,
                             band, mode[5]);
          // Drop frames that repeat the last delivered pair
          if (!have_last || p != last_pos) begin
            have_last = 1'b1;
            last_pos  = p;
            pending_pos.push_back(p);
          end
        end
      end

      if (out_ch.valid && out_ch.ready) begin
        if (pending_pos.size() == 0) begin
          report_mismatch($sformatf("request with nothing owed: x=%0d y=%0d",
                                    out_ch.x_pos, out_ch.y_pos));
        end else begin
          want = pending_pos.pop_front();
          positions_checked++;
          if (out_ch.x_pos !== want.x)
            report_mismatch($sformatf("x_pos got %0d want %0d",
                                      out_ch.x_pos, want.x));
          if (out_ch.y_pos !== want.y)
            report_mismatch($sformatf("y_pos got %0d want %0d",
                                      out_ch.y_pos, want.y));
        end
      end
    end
  end

  // Receiver: stall in stretches of different character, some with no stall
  initial begin
    int hold;
    int style;
    int step;
    out_ch.ready = 1'b0;
    hold  = 0;
    style = 0;
    step  = 0;
    forever begin
      @(negedge clk);
      if (hold == 0) begin
        style = $urandom_range(0, 3);
        hold  = $urandom_range(40, 250);
        step  = 0;
      end
      hold--;
      step++;
      case (style)
        0: out_ch.ready = 1'b1;
        1: out_ch.ready = 1'($urandom_range(0, 1));
        2: out_ch.ready = (step % 23) < 3;   // long stalls
        default: out_ch.ready = ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Send one byte. Start a new burst after a random gap when the current one
  // runs out; hold valid high within a burst. Enter and leave at a falling edge.
  task automatic send_byte(input logic [sfsan_pkg::BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_ch.valid   = 1'b1;
    in_ch.rx_byte = b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [sfsan_pkg::BYTE_W-1:0] a0, a1, a2, a3);
    last_raw[0] = a0;
    last_raw[1] = a1;
    last_raw[2] = a2;
    last_raw[3] = a3;
    send_byte(sfsan_pkg::HEAD_MARK);
    send_byte(a0);
    send_byte(a1);
    send_byte(a2);
    send_byte(a3);
    send_byte(sfsan_pkg::TAIL_MARK);
  endtask

  // Drop valid, wait until every owed position is in, then let any framed
  // byte that produced nothing finish its divisions.
  task automatic wait_idle();
    in_ch.valid = 1'b0;
    burst_left  = 0;
    while (pending_pos.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sfsan_pkg::IDX_W-1:0] idx,
                           input logic [sfsan_pkg::BYTE_W-1:0] data);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [sfsan_pkg::BYTE_W-1:0] xlo, xhi, xmid,
                            input logic [sfsan_pkg::BYTE_W-1:0] ylo, yhi, ymid,
                            input logic [sfsan_pkg::BYTE_W-1:0] dz, am);
    write_reg(sfsan_pkg::REG_X_MIN, xlo);
    write_reg(sfsan_pkg::REG_X_MAX, xhi);
    write_reg(sfsan_pkg::REG_X_CENTER, xmid);
    write_reg(sfsan_pkg::REG_Y_MIN, ylo);
    write_reg(sfsan_pkg::REG_Y_MAX, yhi);
    write_reg(sfsan_pkg::REG_Y_CENTER, ymid);
    write_reg(sfsan_pkg::REG_DEAD_BAND, dz);
    write_reg(sfsan_pkg::REG_AXIS_MODE, am);
    cfg_ch.valid = 1'b0;
  endtask

  // Mix extremes, near-center values and anything else
  function automatic logic [sfsan_pkg::BYTE_W-1:0] pick_raw();
    int c;
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2, 3: begin
        c = int'($urandom_range(0, 1) ? cal_xmid : cal_ymid) +
            int'($urandom_range(0, 40)) - 20;
        if (c < 0)
          c = 0;
        if (c > 255)
          c = 255;
        return c[sfsan_pkg::BYTE_W-1:0];
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Reset calibration: centered, in-band repeat, saturating extremes,
  // overlapping frames and an unframed window.
  task automatic test_reset_defaults();
    send_frame(8'h80, 8'h80, 8'h80, 8'h80);
    send_frame(8'h81, 8'h7F, 8'h86, 8'h7A);   // still in band: no request
    send_frame(8'h00, 8'hFF, 8'h00, 8'hFF);
    // Two framed windows that share bytes
    send_byte(sfsan_pkg::HEAD_MARK);
    send_byte(sfsan_pkg::HEAD_MARK);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(sfsan_pkg::TAIL_MARK);
    send_byte(sfsan_pkg::TAIL_MARK);
    send_byte(sfsan_pkg::TAIL_MARK);
    // Wrong tail mark
    send_byte(sfsan_pkg::HEAD_MARK);
    send_byte(8'h10);
    send_byte(8'h20);
    send_byte(8'h30);
    send_byte(8'h40);
    send_byte(8'hFD);
  endtask

  task automatic test_calibration_extremes();
    // Zero spans fall back to 1, no dead band
    wait_idle();
    set_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(8'h01, 8'h00, 8'h00, 8'h00);
    send_frame(8'hFF, 8'h80, 8'h40, 8'h20);
    // All ones: dead band and mode masked to their widths, both inverted
    wait_idle();
    set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_frame(8'h00, 8'h00, 8'h00, 8'h00);
    send_frame(8'h80, 8'h80, 8'h80, 8'h80);   // edge of the dead band
    send_frame(8'h7F, 8'h7F, 8'h7F, 8'h7F);
    // Inverted full negative travel, raw beyond calibrated travel
    wait_idle();
    set_config(8'h00, 8'hFF, 8'h80, 8'h64, 8'h96, 8'h80, 8'h00, 8'h30);
    send_frame(8'h00, 8'h11, 8'h22, 8'h33);
    send_frame(8'hFF, 8'h11, 8'h22, 8'h33);
    send_frame(8'h81, 8'h11, 8'h22, 8'h33);
    send_frame(8'h7F, 8'h11, 8'h22, 8'h33);
  endtask

  // Walk every axis mode; randomize the unused upper data bits to check masking
  task automatic test_axis_routing();
    wait_idle();
    set_config(8'd14, 8'd235, 8'd126, 8'd18, 8'd232, 8'd130, 8'd8, 8'd0);
    for (int m = 0; m < 64; m++) begin
      wait_idle();
      write_reg(sfsan_pkg::REG_AXIS_MODE, {2'($urandom_range(0, 3)), m[5:0]});
      cfg_ch.valid = 1'b0;
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_config();
    logic [sfsan_pkg::BYTE_W-1:0] v [6];
    for (int i = 0; i < 6; i++)
      v[i] = 8'($urandom_range(0, 255));
    // Mostly sane calibrations, sometimes anything at all
    if ($urandom_range(0, 3) != 0) begin
      v[0] = 8'($urandom_range(0, 100));
      v[1] = 8'($urandom_range(150, 255));
      v[2] = 8'($urandom_range(101, 149));
      v[3] = 8'($urandom_range(0, 100));
      v[4] = 8'($urandom_range(150, 255));
      v[5] = 8'($urandom_range(101, 149));
    end
    set_config(v[0], v[1], v[2], v[3], v[4], v[5],
               {$urandom_range(0, 1) ? 1'b1 : 1'b0,
                ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                            : 7'($urandom_range(0, 24))},
               8'($urandom_range(0, 255)));
  endtask

  // Mostly well-formed frames with random content; the rest noise, broken
  // frames, overlapping frames and exact repeats.
  task automatic test_random_traffic();
    int target;
    logic [sfsan_pkg::BYTE_W-1:0] noise;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      random_config();
      target = bytes_sent +
               (BYTES_TARGET - bytes_sent) / (RANDOM_PHASES - ph);
      while (bytes_sent < target) begin
        case ($urandom_range(0, 19))
          0, 1: begin
            case ($urandom_range(0, 2))
              0: noise = sfsan_pkg::HEAD_MARK;
              1: noise = sfsan_pkg::TAIL_MARK;
              default: noise = 8'($urandom_range(0, 255));
            endcase
            send_byte(noise);
          end
          2: begin
            send_byte(sfsan_pkg::HEAD_MARK);
            send_byte(pick_raw());
            send_byte(pick_raw());
            if ($urandom_range(0, 1)) begin
              send_byte(pick_raw());
              send_byte(pick_raw());
              send_byte(8'($urandom_range(0, 253)));   // anything but a mark
            end
          end
          3: begin
            send_byte(sfsan_pkg::HEAD_MARK);
            send_byte(sfsan_pkg::HEAD_MARK);
            send_byte(pick_raw());
            send_byte(pick_raw());
            send_byte(sfsan_pkg::TAIL_MARK);
            send_byte(sfsan_pkg::TAIL_MARK);
            send_byte(sfsan_pkg::TAIL_MARK);
          end
          4: send_frame(last_raw[0], last_raw[1], last_raw[2], last_raw[3]);
          default: send_frame(pick_raw(), pick_raw(), pick_raw(), pick_raw());
        endcase
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = sfsan_pkg::REG_X_MIN;
    cfg_ch.data   = '0;
    // Reset calibration and an empty window
    cal_xlo   = 8'd14;
    cal_xhi   = 8'd235;
    cal_xmid  = 8'd126;
    cal_ylo   = 8'd18;
    cal_yhi   = 8'd232;
    cal_ymid  = 8'd130;
    band      = 7'd8;
    mode      = 6'd11;
    fill      = 0;
    have_last = 1'b0;
    last_pos  = '0;
    for (int i = 0; i < 4; i++)
      last_raw[i] = '0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_calibration_extremes();
    test_axis_routing();
    test_random_traffic();

    wait_idle();
    $display("Run covered %0d bytes, %0d framed windows, %0d register writes.",
             bytes_sent, frames_seen, cfg_writes);
    $display("Checked %0d position requests, %0d mismatches.",
             positions_checked, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/sfsan_pkg.sv
hdl/sfsan_if.sv
hdl/sfsan_div.sv
hdl/sfsan_dp.sv
hdl/sfsan_ctrl.sv
hdl/stick_frame_sync_axis_normalizer_core.sv
tb/tb_stick_frame_sync_axis_normalizer_core.sv
